// ===== rtl/rcph_pkg.sv =====
package rcph_pkg;

   // Polygon table size and the widths that follow from it.
   localparam int MAX_VERTICES = 16;
   localparam int IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CNT_W = $clog2(MAX_VERTICES + 2);

   // Fixed widths of the 12.4 coordinate arithmetic.
   localparam int COORD_W = 16;
   localparam int SIZE_W = 15;
   localparam int KIND_W = 2;
   localparam int VCNT_W = 5;
   localparam int CORNER_W = COORD_W + 1;
   localparam int DIFF_W = CORNER_W + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int NUM_CORNERS = 4;

   // Twice the mirror axis x = 86.0 in 12.4 fixed point.
   localparam logic signed [CORNER_W-1:0] MIRROR_TWICE_MID = 17'sd2752;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7FFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;

   // Depth of the command queue between front and back.
   localparam int CMD_DEPTH = 2;
   localparam int CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   // Codes of the kind field of an input item.
   typedef enum logic [KIND_W-1:0] {
      KIND_WRITE  = 2'd0,
      KIND_QUERY  = 2'd1,
      KIND_MIRROR = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   // Operations that the back end carries out.
   typedef enum logic [1:0] {
      OP_WRITE,
      OP_QUERY,
      OP_MIRROR,
      OP_MISS
   } op_type;

   // Back end sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_REPORT
   } back_state_type;

   // One classified command as it travels through the queue.
   typedef struct packed {
      op_type                      op;
      logic [IDX_W-1:0]            idx;
      logic signed [COORD_W-1:0]   vx;
      logic signed [COORD_W-1:0]   vy;
      logic signed [COORD_W-1:0]   ox;
      logic signed [COORD_W-1:0]   oy;
      logic signed [CORNER_W-1:0]  px0;
      logic signed [CORNER_W-1:0]  px1;
      logic signed [CORNER_W-1:0]  py0;
      logic signed [CORNER_W-1:0]  py1;
   } cmd_type;

endpackage

// ===== rtl/rect_corner_polygon_hit_test_top.sv =====
// Polygon hit test of a rectangle's four corners, signed 12.4 coordinates.
// Input side is a queue: drive the item on the req_ ports with req_push high;
// it is taken at a clock edge where req_full is low. A write item stores one
// vertex, a mirror item reflects each vertex x in use about 86.0, a query
// item tests the rectangle against the polygon shifted by the body offset.
// Results come out of a queue: rsp_hit is valid while rsp_empty is low and
// is taken at an edge where rsp_pop is high. Only query items give a result.
// The csr_ port writes the vertex count; change it only while the block idles.
// The back end carries out a write straight from idle, a mirror as a sweep
// of the vertices in use and a drain, a dying query as a report alone, and
// a query as a sweep of the vertices in use, a drain and a report.
// The query walks the vertex memory one edge per cycle through its single
// read port, with four corner units side by side; items are carried out one
// at a time at that pace. A two-entry command queue decouples the input from
// the back end and a two-entry result queue holds answers while the receiver
// stalls. req_full is high whenever the command queue is full, so a long
// query or a stalled receiver blocks the input. Reset empties both queues and
// sets the vertex count to 3; the vertex table holds no values until written.
module rect_corner_polygon_hit_test_top import rcph_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [KIND_W-1:0]          req_kind,
   input  logic [3:0]                 req_vertex_index,
   input  logic signed [COORD_W-1:0]  req_vertex_x,
   input  logic signed [COORD_W-1:0]  req_vertex_y,
   input  logic signed [COORD_W-1:0]  req_rect_x,
   input  logic signed [COORD_W-1:0]  req_rect_y,
   input  logic [SIZE_W-1:0]          req_rect_width,
   input  logic [SIZE_W-1:0]          req_rect_height,
   input  logic signed [COORD_W-1:0]  req_body_x,
   input  logic signed [COORD_W-1:0]  req_body_y,
   input  logic                       req_dying,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic                       rsp_hit,
   input  logic                       csr_we,
   input  logic [VCNT_W-1:0]          csr_wdata
);

   logic [VCNT_W-1:0]  vertex_count_ff;
   logic               cmd_push;
   cmd_type            cmd_front;
   logic               cmd_full;
   logic               cmd_pop;
   logic               cmd_empty;
   cmd_type            cmd_back;

   // Vertex count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= VCNT_W'(3);
      end else if (csr_we) begin
         vertex_count_ff <= csr_wdata;
      end
   end

   assign req_full = cmd_full;

   rcph_front u_front (
      .req_push         (req_push),
      .queue_full       (cmd_full),
      .req_kind         (req_kind),
      .req_vertex_index (req_vertex_index),
      .req_vertex_x     (req_vertex_x),
      .req_vertex_y     (req_vertex_y),
      .req_rect_x       (req_rect_x),
      .req_rect_y       (req_rect_y),
      .req_rect_width   (req_rect_width),
      .req_rect_height  (req_rect_height),
      .req_body_x       (req_body_x),
      .req_body_y       (req_body_y),
      .req_dying        (req_dying),
      .cmd_push         (cmd_push),
      .cmd              (cmd_front)
   );

   rcph_cmd_queue u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .cmd_in  (cmd_front),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .empty   (cmd_empty),
      .cmd_out (cmd_back)
   );

   rcph_back u_back (
      .clock        (clock),
      .reset        (reset),
      .vertex_count (vertex_count_ff),
      .cmd_empty    (cmd_empty),
      .cmd          (cmd_back),
      .cmd_pop      (cmd_pop),
      .rsp_empty    (rsp_empty),
      .rsp_hit      (rsp_hit),
      .rsp_pop      (rsp_pop)
   );

endmodule

// ===== rtl/rcph_front.sv =====
module rcph_front import rcph_pkg::*; (
   input  logic                       req_push,
   input  logic                       queue_full,
   input  logic [KIND_W-1:0]          req_kind,
   input  logic [3:0]                 req_vertex_index,
   input  logic signed [COORD_W-1:0]  req_vertex_x,
   input  logic signed [COORD_W-1:0]  req_vertex_y,
   input  logic signed [COORD_W-1:0]  req_rect_x,
   input  logic signed [COORD_W-1:0]  req_rect_y,
   input  logic [SIZE_W-1:0]          req_rect_width,
   input  logic [SIZE_W-1:0]          req_rect_height,
   input  logic signed [COORD_W-1:0]  req_body_x,
   input  logic signed [COORD_W-1:0]  req_body_y,
   input  logic                       req_dying,
   output logic                       cmd_push,
   output cmd_type                    cmd
);

   logic keep;

   // Build the command: payload, rectangle corners and the decoded kind.
   // Unknown kinds and out-of-range writes are dropped.
   always_comb begin
      cmd.idx = IDX_W'(req_vertex_index);
      cmd.vx = req_vertex_x;
      cmd.vy = req_vertex_y;
      cmd.ox = req_body_x;
      cmd.oy = req_body_y;
      cmd.px0 = CORNER_W'(req_rect_x);
      cmd.py0 = CORNER_W'(req_rect_y);
      cmd.px1 = CORNER_W'(req_rect_x) + CORNER_W'($signed({1'b0, req_rect_width}));
      cmd.py1 = CORNER_W'(req_rect_y) + CORNER_W'($signed({1'b0, req_rect_height}));
      keep = 1'b0;
      cmd.op = OP_WRITE;
      case (kind_type'(req_kind))
         KIND_WRITE: begin
            cmd.op = OP_WRITE;
            keep = (int'(req_vertex_index) < MAX_VERTICES);
         end
         KIND_QUERY: begin
            cmd.op = req_dying ? OP_MISS : OP_QUERY;
            keep = 1'b1;
         end
         KIND_MIRROR: begin
            cmd.op = OP_MIRROR;
            keep = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign cmd_push = req_push & ~queue_full & keep;

endmodule

// ===== rtl/rcph_cmd_queue.sv =====
module rcph_cmd_queue import rcph_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  cmd_type  cmd_in,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output cmd_type  cmd_out
);

   cmd_type                entry_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff;
   logic [CMD_CNT_W-1:0]   count_ff;
   logic                   do_push;
   logic                   do_pop;

   assign full = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop = pop & ~empty;
   assign cmd_out = entry_ff[rd_ptr_ff];

   // Storage of queued items.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (int'(wr_ptr_ff) == CMD_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (int'(rd_ptr_ff) == CMD_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
         end
         case ({do_push, do_pop})
            2'b10: count_ff <= count_ff + 1'b1;
            2'b01: count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// ===== rtl/rcph_back.sv =====
module rcph_back import rcph_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [VCNT_W-1:0]  vertex_count,
   input  logic               cmd_empty,
   input  cmd_type            cmd,
   output logic               cmd_pop,
   output logic               rsp_empty,
   output logic               rsp_hit,
   input  logic               rsp_pop
);

   back_state_type state_ff, state_in;
   logic                        is_query_ff, is_query_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [CNT_W-1:0]            used_n;
   logic [CNT_W-1:0]            addr_full;
   logic                        last;
   logic                        clear_inside;
   logic                        wr_cmd;
   logic                        res_push;

   // Operands held for the running command.
   logic signed [COORD_W-1:0]   ox_ff, oy_ff;
   logic signed [CORNER_W-1:0]  px_ff [NUM_CORNERS];
   logic signed [CORNER_W-1:0]  py_ff [NUM_CORNERS];

   // Vertex memory and its read pipeline.
   logic [2*COORD_W-1:0]        vtx_mem [MAX_VERTICES];
   logic [2*COORD_W-1:0]        rd_data_ff;
   logic                        rd_en;
   logic                        rd_first;
   logic [IDX_W-1:0]            rd_addr;
   logic                        rd_vld_ff;
   logic                        rd_first_ff;
   logic [IDX_W-1:0]            rd_addr_ff;
   logic                        mem_we;
   logic [IDX_W-1:0]            mem_waddr;
   logic [2*COORD_W-1:0]        mem_wdata;
   logic signed [COORD_W-1:0]   rd_x, rd_y;
   logic signed [CORNER_W-1:0]  mir_x;
   logic signed [COORD_W-1:0]   mir_sat;

   // Edge pipeline.
   logic signed [CORNER_W-1:0]  cur_x_ff, cur_y_ff, prev_x_ff, prev_y_ff;
   logic                        edge_vld_ff;
   logic signed [DIFF_W-1:0]    d_y;
   logic signed [DIFF_W-1:0]    d_x;
   logic signed [DIFF_W-1:0]    a_x [NUM_CORNERS];
   logic signed [DIFF_W-1:0]    c_y [NUM_CORNERS];
   logic signed [PROD_W-1:0]    lhs [NUM_CORNERS];
   logic signed [PROD_W-1:0]    rhs [NUM_CORNERS];
   logic [NUM_CORNERS-1:0]      crosses;
   logic signed [PROD_W-1:0]    lhs_ff [NUM_CORNERS];
   logic signed [PROD_W-1:0]    rhs_ff [NUM_CORNERS];
   logic [NUM_CORNERS-1:0]      cross_ff;
   logic                        dneg_ff;
   logic                        prod_vld_ff;
   logic [NUM_CORNERS-1:0]      inside_ff;
   logic [NUM_CORNERS-1:0]      toggle;

   // Result queue.
   logic                        res_q_ff [2];
   logic                        res_wr_ff, res_rd_ff;
   logic [1:0]                  res_cnt_ff;
   logic                        res_pop;

   // Vertex count in use, capped at the table size.
   assign used_n = (int'(vertex_count) > MAX_VERTICES) ? CNT_W'(MAX_VERTICES)
                                                       : CNT_W'(vertex_count);

   // Sequencer state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         is_query_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         is_query_ff <= is_query_in;
         cnt_ff <= cnt_in;
      end
   end

   // Sequencer: take a command, sweep the vertices, drain, report.
   always_comb begin
      state_in = state_ff;
      is_query_in = is_query_ff;
      cnt_in = cnt_ff;
      cmd_pop = 1'b0;
      rd_en = 1'b0;
      rd_first = 1'b0;
      addr_full = '0;
      last = 1'b0;
      clear_inside = 1'b0;
      wr_cmd = 1'b0;
      res_push = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               cnt_in = '0;
               case (cmd.op)
                  OP_WRITE: begin
                     wr_cmd = 1'b1;
                  end
                  OP_MIRROR: begin
                     is_query_in = 1'b0;
                     if (used_n != '0) begin
                        state_in = ST_RUN;
                     end
                  end
                  OP_QUERY: begin
                     clear_inside = 1'b1;
                     is_query_in = 1'b1;
                     state_in = (used_n != '0) ? ST_RUN : ST_REPORT;
                  end
                  OP_MISS: begin
                     clear_inside = 1'b1;
                     is_query_in = 1'b1;
                     state_in = ST_REPORT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_RUN: begin
            rd_en = 1'b1;
            if (is_query_ff) begin
               // The last vertex is read first so that it closes the polygon.
               rd_first = (cnt_ff == '0);
               addr_full = (cnt_ff == '0) ? used_n - 1'b1 : cnt_ff - 1'b1;
               last = (cnt_ff == used_n);
            end else begin
               addr_full = cnt_ff;
               last = (cnt_ff == used_n - 1'b1);
            end
            cnt_in = cnt_ff + 1'b1;
            if (last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_vld_ff && !edge_vld_ff && !prod_vld_ff) begin
               state_in = is_query_ff ? ST_REPORT : ST_IDLE;
            end
         end
         ST_REPORT: begin
            if (res_cnt_ff != 2'd2) begin
               res_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rd_addr = addr_full[IDX_W-1:0];

   // Operands of the command just taken.
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         ox_ff <= cmd.ox;
         oy_ff <= cmd.oy;
         px_ff[0] <= cmd.px0;
         py_ff[0] <= cmd.py0;
         px_ff[1] <= cmd.px1;
         py_ff[1] <= cmd.py0;
         px_ff[2] <= cmd.px1;
         py_ff[2] <= cmd.py1;
         px_ff[3] <= cmd.px0;
         py_ff[3] <= cmd.py1;
      end
   end

   // Mirror write-back: x becomes 2752 - x, saturated to 16 bits.
   assign rd_x = rd_data_ff[2*COORD_W-1:COORD_W];
   assign rd_y = rd_data_ff[COORD_W-1:0];
   assign mir_x = MIRROR_TWICE_MID - CORNER_W'(rd_x);
   assign mir_sat = (mir_x[CORNER_W-1] == mir_x[CORNER_W-2]) ? mir_x[COORD_W-1:0]
                  : (mir_x[CORNER_W-1] ? COORD_MIN : COORD_MAX);

   assign mem_we = wr_cmd | (rd_vld_ff & ~is_query_ff);
   assign mem_waddr = wr_cmd ? cmd.idx : rd_addr_ff;
   assign mem_wdata = wr_cmd ? {cmd.vx, cmd.vy} : {mir_sat, rd_y};

   // Vertex memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         vtx_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= vtx_mem[rd_addr];
      end
   end

   // Read pipeline control.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         rd_first_ff <= 1'b0;
      end else begin
         rd_vld_ff <= rd_en;
         rd_first_ff <= rd_first;
      end
      rd_addr_ff <= rd_addr;
   end

   // Offset vertex stage: current and previous vertex form one edge.
   always_ff @(posedge clock) begin
      if (reset) begin
         edge_vld_ff <= 1'b0;
      end else begin
         edge_vld_ff <= rd_vld_ff & is_query_ff & ~rd_first_ff;
      end
      if (rd_vld_ff && is_query_ff) begin
         cur_x_ff <= CORNER_W'(rd_x) + CORNER_W'(ox_ff);
         cur_y_ff <= CORNER_W'(rd_y) + CORNER_W'(oy_ff);
         prev_x_ff <= cur_x_ff;
         prev_y_ff <= cur_y_ff;
      end
   end

   // Edge stage: crossing test and the two cross products for each corner.
   assign d_y = DIFF_W'(prev_y_ff) - DIFF_W'(cur_y_ff);
   assign d_x = DIFF_W'(prev_x_ff) - DIFF_W'(cur_x_ff);

   always_comb begin
      for (int c = 0; c < NUM_CORNERS; c++) begin
         a_x[c] = DIFF_W'(px_ff[c]) - DIFF_W'(cur_x_ff);
         c_y[c] = DIFF_W'(py_ff[c]) - DIFF_W'(cur_y_ff);
         crosses[c] = (cur_y_ff > py_ff[c]) != (prev_y_ff > py_ff[c]);
         lhs[c] = PROD_W'(a_x[c]) * PROD_W'(d_y);
         rhs[c] = PROD_W'(d_x) * PROD_W'(c_y[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= edge_vld_ff;
      end
      for (int c = 0; c < NUM_CORNERS; c++) begin
         lhs_ff[c] <= lhs[c];
         rhs_ff[c] <= rhs[c];
      end
      cross_ff <= crosses;
      dneg_ff <= d_y[DIFF_W-1];
   end

   // Compare stage: the even-odd flag of each corner flips on a left crossing.
   always_comb begin
      for (int c = 0; c < NUM_CORNERS; c++) begin
         toggle[c] = cross_ff[c] & (dneg_ff ? (lhs_ff[c] > rhs_ff[c])
                                            : (lhs_ff[c] < rhs_ff[c]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear_inside) begin
         inside_ff <= '0;
      end else if (prod_vld_ff) begin
         inside_ff <= inside_ff ^ toggle;
      end
   end

   // Two-entry result queue toward the receiver.
   assign rsp_empty = (res_cnt_ff == 2'd0);
   assign rsp_hit = res_q_ff[res_rd_ff];
   assign res_pop = rsp_pop & ~rsp_empty;

   always_ff @(posedge clock) begin
      if (res_push) begin
         res_q_ff[res_wr_ff] <= |inside_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_wr_ff <= 1'b0;
         res_rd_ff <= 1'b0;
         res_cnt_ff <= 2'd0;
      end else begin
         if (res_push) begin
            res_wr_ff <= ~res_wr_ff;
         end
         if (res_pop) begin
            res_rd_ff <= ~res_rd_ff;
         end
         case ({res_push, res_pop})
            2'b10: res_cnt_ff <= res_cnt_ff + 2'd1;
            2'b01: res_cnt_ff <= res_cnt_ff - 2'd1;
            default: res_cnt_ff <= res_cnt_ff;
         endcase
      end
   end

endmodule

// ===== bench/polygon_hit_checker.sv =====
`timescale 1ns / 100ps

// Watches both queue channels and the count register, predicts the hit answer
// of every accepted query and compares it with the answers that come out.
module polygon_hit_checker import rcph_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   input  logic                       req_full,
   input  logic [KIND_W-1:0]          req_kind,
   input  logic [3:0]                 req_vertex_index,
   input  logic signed [COORD_W-1:0]  req_vertex_x,
   input  logic signed [COORD_W-1:0]  req_vertex_y,
   input  logic signed [COORD_W-1:0]  req_rect_x,
   input  logic signed [COORD_W-1:0]  req_rect_y,
   input  logic [SIZE_W-1:0]          req_rect_width,
   input  logic [SIZE_W-1:0]          req_rect_height,
   input  logic signed [COORD_W-1:0]  req_body_x,
   input  logic signed [COORD_W-1:0]  req_body_y,
   input  logic                       req_dying,
   input  logic                       rsp_empty,
   input  logic                       rsp_pop,
   input  logic                       rsp_hit,
   input  logic                       csr_we,
   input  logic [VCNT_W-1:0]          csr_wdata,
   output int                         mismatches,
   output int                         expected_left
);

   // Our own copy of the vertex table and of the vertex count.
   logic signed [COORD_W-1:0] shape_x [MAX_VERTICES];
   logic signed [COORD_W-1:0] shape_y [MAX_VERTICES];
   logic [VCNT_W-1:0]         live_count = 5'd3;

   // Hit answers of accepted queries, oldest first.
   logic hits_due [$];
   int   bad_hits = 0;

   initial begin
      mismatches = 0;
      expected_left = 0;
   end

   // A count above the table size uses the whole table.
   function automatic int shape_size();
      return (live_count > MAX_VERTICES) ? MAX_VERTICES : int'(live_count);
   endfunction

   // Even-odd crossing test of one point against the polygon moved by (ox, oy).
   // The intercept is compared by cross multiplication, so nothing rounds.
   function automatic logic corner_inside(longint px, longint py, longint ox,
                                          longint oy);
      int     n;
      int     j;
      logic   in_poly;
      longint xi, yi, xj, yj, d, lhs, rhs;
      n = shape_size();
      in_poly = 1'b0;
      j = n - 1;
      for (int i = 0; i < n; i++) begin
         xi = longint'(shape_x[i]) + ox;
         yi = longint'(shape_y[i]) + oy;
         xj = longint'(shape_x[j]) + ox;
         yj = longint'(shape_y[j]) + oy;
         if ((yi > py) != (yj > py)) begin
            d = yj - yi;
            lhs = (px - xi) * d;
            rhs = (xj - xi) * (py - yi);
            if ((d > 0) ? (lhs < rhs) : (lhs > rhs)) in_poly = !in_poly;
         end
         j = i;
      end
      return in_poly;
   endfunction

   // A rectangle hits when any of its four corners lies inside.
   function automatic logic rect_hits_polygon();
      longint rx, ry, rw, rh, ox, oy;
      rx = longint'(req_rect_x);
      ry = longint'(req_rect_y);
      rw = longint'(req_rect_width);
      rh = longint'(req_rect_height);
      ox = longint'(req_body_x);
      oy = longint'(req_body_y);
      return corner_inside(rx, ry, ox, oy) || corner_inside(rx + rw, ry, ox, oy) ||
             corner_inside(rx + rw, ry + rh, ox, oy) || corner_inside(rx, ry + rh, ox, oy);
   endfunction

   // Reflect every vertex in use about x = 86.0, saturating at the 16-bit range.
   task automatic mirror_shape();
      int v;
      for (int k = 0; k < shape_size(); k++) begin
         v = int'(MIRROR_TWICE_MID) - int'(shape_x[k]);
         if (v > int'(COORD_MAX)) v = int'(COORD_MAX);
         if (v < int'(COORD_MIN)) v = int'(COORD_MIN);
         shape_x[k] = COORD_W'(v);
      end
   endtask

   task automatic flag_bad(input string what, input logic want, input logic got);
      bad_hits++;
      if (bad_hits <= 10)
         $display("%0t: %s: expected hit %0b, got %0b", $time, what, want, got);
   endtask

   // Results are checked before new items are predicted, so an answer that
   // arrives with no query waiting is never matched to one accepted at the same edge.
   always @(posedge clock) begin : watch
      logic want;
      if (reset) begin
         hits_due.delete();
         live_count = 5'd3;
      end else begin
         if (csr_we) live_count = csr_wdata;
         if (!rsp_empty && rsp_pop) begin
            if (hits_due.size() == 0) begin
               flag_bad("result with no query waiting", 1'bx, rsp_hit);
            end else begin
               want = hits_due.pop_front();
               if (rsp_hit !== want) flag_bad("wrong hit", want, rsp_hit);
            end
         end
         if (req_push && !req_full) begin
            case (kind_type'(req_kind))
               KIND_WRITE: begin
                  shape_x[req_vertex_index] = req_vertex_x;
                  shape_y[req_vertex_index] = req_vertex_y;
               end
               KIND_MIRROR: mirror_shape();
               KIND_QUERY: hits_due.push_back(!req_dying && rect_hits_polygon());
               default: ;
            endcase
         end
      end
      mismatches <= bad_hits;
      expected_left <= hits_due.size();
   end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench import rcph_pkg::*;;

   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 80;

   // One input item as the sender sees it.
   typedef struct {
      kind_type                  kind;
      logic [3:0]                index;
      logic signed [COORD_W-1:0] vx;
      logic signed [COORD_W-1:0] vy;
      logic signed [COORD_W-1:0] rx;
      logic signed [COORD_W-1:0] ry;
      logic [SIZE_W-1:0]         rw;
      logic [SIZE_W-1:0]         rh;
      logic signed [COORD_W-1:0] bx;
      logic signed [COORD_W-1:0] by;
      logic                      dying;
   } hit_item;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_push = 1'b0;
   logic                      req_full;
   logic [KIND_W-1:0]         req_kind = KIND_NONE;
   logic [3:0]                req_vertex_index = '0;
   logic signed [COORD_W-1:0] req_vertex_x = '0;
   logic signed [COORD_W-1:0] req_vertex_y = '0;
   logic signed [COORD_W-1:0] req_rect_x = '0;
   logic signed [COORD_W-1:0] req_rect_y = '0;
   logic [SIZE_W-1:0]         req_rect_width = '0;
   logic [SIZE_W-1:0]         req_rect_height = '0;
   logic signed [COORD_W-1:0] req_body_x = '0;
   logic signed [COORD_W-1:0] req_body_y = '0;
   logic                      req_dying = 1'b0;
   logic                      rsp_empty;
   logic                      rsp_pop = 1'b0;
   logic                      rsp_hit;
   logic                      csr_we = 1'b0;
   logic [VCNT_W-1:0]         csr_wdata = '0;
   int                        mismatches;
   int                        expected_left;

   int send_calm = 0;
   int holds_asked = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   rect_corner_polygon_hit_test_top dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_kind(req_kind),
      .req_vertex_index(req_vertex_index), .req_vertex_x(req_vertex_x),
      .req_vertex_y(req_vertex_y), .req_rect_x(req_rect_x), .req_rect_y(req_rect_y),
      .req_rect_width(req_rect_width), .req_rect_height(req_rect_height),
      .req_body_x(req_body_x), .req_body_y(req_body_y), .req_dying(req_dying),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_hit(rsp_hit),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   polygon_hit_checker checker_i (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_kind(req_kind),
      .req_vertex_index(req_vertex_index), .req_vertex_x(req_vertex_x),
      .req_vertex_y(req_vertex_y), .req_rect_x(req_rect_x), .req_rect_y(req_rect_y),
      .req_rect_width(req_rect_width), .req_rect_height(req_rect_height),
      .req_body_x(req_body_x), .req_body_y(req_body_y), .req_dying(req_dying),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_hit(rsp_hit),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .mismatches(mismatches), .expected_left(expected_left)
   );

   // Wait before the next item: mostly a random gap, now and then a calm
   // stretch with no waiting at all.
   function automatic int pick_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         calm = $urandom_range(15, 50);
         return 0;
      end
      return $urandom_range(0, 11);
   endfunction

   function automatic logic signed [COORD_W-1:0] clip16(int v);
      if (v > 32767) return COORD_MAX;
      if (v < -32768) return COORD_MIN;
      return COORD_W'(v);
   endfunction

   function automatic int spread_val(int r);
      return int'($urandom_range(0, 2 * r)) - r;
   endfunction

   // A random 16-bit value that lands on either extreme now and then.
   function automatic logic signed [COORD_W-1:0] wild16();
      case ($urandom_range(0, 7))
         0: return COORD_MIN;
         1: return COORD_MAX;
         default: return COORD_W'($urandom);
      endcase
   endfunction

   // Every field random over its full range, the kind included.
   function automatic hit_item noise_item();
      hit_item it;
      it.kind = kind_type'($urandom_range(0, 3));
      it.index = 4'($urandom);
      it.vx = wild16();
      it.vy = wild16();
      it.rx = wild16();
      it.ry = wild16();
      it.rw = SIZE_W'(wild16());
      it.rh = SIZE_W'(wild16());
      it.bx = wild16();
      it.by = wild16();
      it.dying = 1'($urandom);
      return it;
   endfunction

   function automatic hit_item vertex_item(int idx, int x, int y);
      hit_item it;
      it = noise_item();
      it.kind = KIND_WRITE;
      it.index = 4'(idx);
      it.vx = clip16(x);
      it.vy = clip16(y);
      return it;
   endfunction

   function automatic hit_item query_at(int rx, int ry, int rw, int rh, int bx, int by,
                                        logic dying);
      hit_item it;
      it = noise_item();
      it.kind = KIND_QUERY;
      it.rx = clip16(rx);
      it.ry = clip16(ry);
      it.rw = SIZE_W'(rw);
      it.rh = SIZE_W'(rh);
      it.bx = clip16(bx);
      it.by = clip16(by);
      it.dying = dying;
      return it;
   endfunction

   function automatic hit_item kind_only(kind_type kind);
      hit_item it;
      it = noise_item();
      it.kind = kind;
      return it;
   endfunction

   // A query whose rectangle lies around the body, so corners often fall inside.
   function automatic hit_item aimed_query(int reach);
      int bx, by, w, h;
      bx = ($urandom_range(0, 3) == 0) ? int'(wild16()) : spread_val(8000);
      by = ($urandom_range(0, 3) == 0) ? int'(wild16()) : spread_val(8000);
      w = $urandom_range(0, reach);
      h = $urandom_range(0, reach);
      return query_at(bx + spread_val(reach) - w / 2, by + spread_val(reach) - h / 2,
                      w, h, bx, by, $urandom_range(0, 9) == 0);
   endfunction

   // Offer one item and hold it until the block takes it.
   task automatic send(input hit_item it);
      int gap;
      req_kind <= it.kind;
      req_vertex_index <= it.index;
      req_vertex_x <= it.vx;
      req_vertex_y <= it.vy;
      req_rect_x <= it.rx;
      req_rect_y <= it.ry;
      req_rect_width <= it.rw;
      req_rect_height <= it.rh;
      req_body_x <= it.bx;
      req_body_y <= it.by;
      req_dying <= it.dying;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      gap = pick_gap(send_calm);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering, wait for every answer, then let writes and mirrors finish.
   task automatic settle();
      req_push <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_count(int value);
      csr_we <= 1'b1;
      csr_wdata <= VCNT_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Receiver: random pops, plus a long hold-off whenever the sender asks.
   initial begin : take_results
      int gap;
      int calm;
      int holds_done;
      calm = 0;
      holds_done = 0;
      wait (!reset);
      forever begin
         if (holds_asked != holds_done) begin
            holds_done = holds_asked;
            gap = HOLD_CYCLES;
         end else begin
            gap = pick_gap(calm);
         end
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
      end
   end

   // The run cannot take this long unless the block has stopped answering.
   initial begin : watchdog
      #8_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin : stimulus
      int     settings [9];
      int     spreads [4];
      int     used, spread, done, roll;
      hit_item it;
      settings = '{16, 31, 3, 17, 8, 12, 0, 0, 5};
      spreads = '{16, 240, 2400, 7000};
      settings[6] = $urandom_range(3, 16);
      settings[7] = $urandom_range(0, 31);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, at the reset count of three: a right triangle of 100 units.
      send(vertex_item(0, 0, 0));
      send(vertex_item(1, 1600, 0));
      send(vertex_item(2, 0, 1600));
      send(query_at(100, 100, 50, 50, 0, 0, 1'b0));
      send(query_at(100, 100, 50, 50, 0, 0, 1'b1));
      send(query_at(5000, 5000, 0, 0, 0, 0, 1'b0));
      // Rectangle covers the whole triangle, but no corner lies inside it.
      send(query_at(-100, -100, 2000, 2000, 0, 0, 1'b0));
      send(query_at(-32668, -32668, 0, 0, -32768, -32768, 1'b0));
      send(query_at(32767, 32767, 32767, 32767, 32767, 32767, 1'b0));
      send(query_at(-32768, -32768, 32767, 32767, 0, 0, 1'b0));
      send(kind_only(KIND_MIRROR));
      send(query_at(2600, 100, 0, 0, 0, 0, 1'b0));
      // Extreme vertices; the mirror of the most negative x saturates.
      send(vertex_item(1, 32767, -32768));
      send(vertex_item(2, -32768, 32767));
      send(kind_only(KIND_MIRROR));
      send(query_at(200, 200, 30000, 30000, 0, 0, 1'b0));
      send(kind_only(KIND_NONE));
      settle();

      // Counts too small to enclose anything.
      for (int c = 0; c < 3; c++) begin
         set_count(c);
         send(query_at(100, 100, 50, 50, 0, 0, 1'b0));
         settle();
      end

      // Random phases: load a fresh polygon, then mostly aimed queries.
      for (int ph = 0; ph < 9; ph++) begin
         set_count(settings[ph]);
         used = (settings[ph] > MAX_VERTICES) ? MAX_VERTICES : settings[ph];
         spread = spreads[$urandom_range(0, 3)];
         for (int k = 0; k < used; k++)
            send(vertex_item(k, spread_val(spread), spread_val(spread)));
         done = 0;
         while (done < 220) begin
            roll = $urandom_range(0, 99);
            if (roll < 68) it = aimed_query(2 * spread);
            else if (roll < 76) it = kind_only(KIND_MIRROR);
            else if (roll < 84)
               it = vertex_item($urandom_range(0, 15), spread_val(spread),
                                spread_val(spread));
            else it = noise_item();
            send(it);
            if (it.kind != KIND_NONE) begin
               done++;
               // Stall the receiver so both queues fill and the input blocks.
               if ((ph == 1 || ph == 5) && done == 80) holds_asked <= holds_asked + 1;
            end
         end
         settle();
      end

      if (mismatches == 0 && expected_left == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== rect_corner_polygon_hit_test_top.f =====
rtl/rcph_pkg.sv
rtl/rcph_front.sv
rtl/rcph_cmd_queue.sv
rtl/rcph_back.sv
rtl/rect_corner_polygon_hit_test_top.sv
bench/polygon_hit_checker.sv
bench/testbench.sv
